### src/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define VMB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while reset is held.
`define VMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### src/vmb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vmb_pkg;

    localparam int POS_W     = 24;
    localparam int MASS_W    = 32;
    localparam int TOTAL_W   = 48;
    localparam int SUM_W     = TOTAL_W + 1;
    localparam int IDX_W     = 5;
    localparam int DIV_BITS  = 3;
    localparam int DIV_STEPS = (POS_W + DIV_BITS - 1) / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [POS_W-1:0]   CELL_RESET = 24'd10240;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic               func;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [POS_W-1:0]   pos_z;
        logic [MASS_W-1:0]  mass;
        logic [IDX_W-1:0]   read_x;
        logic [IDX_W-1:0]   read_y;
        logic [IDX_W-1:0]   read_z;
        logic               clear_after_read;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   voxel_x;
        logic [IDX_W-1:0]   voxel_y;
        logic [IDX_W-1:0]   voxel_z;
        logic [TOTAL_W-1:0] voxel_mass;
        logic               in_grid;
        logic               saturated;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_ADDR,
        ST_READ,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic div_step;
        logic calc_addr;
        logic mem_rd;
        logic mem_upd;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
    } dp_status_t;

endpackage

`default_nettype wire

### src/vmb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module vmb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

### src/vmb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module vmb_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                func,
    input  wire vmb_pkg::dp_status_t status,
    output vmb_pkg::dp_cmd_t         cmd,
    output logic                     busy,
    output logic                     done
);

    vmb_pkg::state_t                 state_reg, state_next;
    logic [vmb_pkg::STEP_W-1:0]      step_reg, step_next;
    logic                            done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vmb_pkg::ST_CLEAR;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            vmb_pkg::ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = vmb_pkg::ST_IDLE;
                end
            end
            vmb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = func ? vmb_pkg::ST_ADDR : vmb_pkg::ST_DIV;
                end
            end
            vmb_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == vmb_pkg::STEP_W'(vmb_pkg::DIV_STEPS - 1))
                begin
                    state_next = vmb_pkg::ST_ADDR;
                end
            end
            vmb_pkg::ST_ADDR:
            begin
                cmd.calc_addr = 1'b1;
                state_next    = vmb_pkg::ST_READ;
            end
            vmb_pkg::ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = vmb_pkg::ST_UPDATE;
            end
            vmb_pkg::ST_UPDATE:
            begin
                cmd.mem_upd = 1'b1;
                done_next   = 1'b1;
                state_next  = vmb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = vmb_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != vmb_pkg::ST_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

### src/vmb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module vmb_datapath #(
    parameter int GRID_SIDE = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [vmb_pkg::POS_W-1:0]   cfg_data,
    input  wire vmb_pkg::item_t              item,
    input  wire vmb_pkg::dp_cmd_t            cmd,
    output vmb_pkg::dp_status_t              status,
    output vmb_pkg::result_t                 result
);

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int DEPTH = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = vmb_pkg::POS_W;
    localparam int TW    = vmb_pkg::TOTAL_W;

    logic [PW-1:0]            cell_size_reg;
    logic [AW-1:0]            clr_cnt_reg;
    vmb_pkg::item_t           item_reg;
    logic [PW-1:0]            quo_reg  [3];
    logic [PW-1:0]            rem_reg  [3];
    logic [PW-1:0]            quo_next [3];
    logic [PW-1:0]            rem_next [3];
    logic [PW-1:0]            pos_in   [3];
    logic [AW-1:0]            addr_reg, addr_next;
    logic                     inside_reg, inside_next;
    vmb_pkg::result_t         result_reg, result_next;

    logic                     mem_en, mem_we, wr_upd;
    logic [AW-1:0]            mem_addr;
    logic [TW-1:0]            mem_wdata, mem_rdata;
    logic [vmb_pkg::SUM_W-1:0] sum;
    logic [TW-1:0]            sum_sat;

    assign pos_in[0] = item.pos_x;
    assign pos_in[1] = item.pos_y;
    assign pos_in[2] = item.pos_z;

    // cell size register, reset to 10.0, and clear sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg <= vmb_pkg::CELL_RESET;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cell_size_reg <= cfg_data;
            end
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    assign status.clr_last = (clr_cnt_reg == AW'(DEPTH - 1));

    // restoring divider, three lanes, DIV_BITS quotient bits per cycle
    always_comb
    begin : div_comb
        logic [PW:0]   shifted;
        logic [PW-1:0] r;
        logic [PW-1:0] q;
        for (int i = 0; i < 3; i++)
        begin
            r = rem_reg[i];
            q = quo_reg[i];
            for (int j = 0; j < vmb_pkg::DIV_BITS; j++)
            begin
                shifted = {r, q[PW-1]};
                q       = {q[PW-2:0], 1'b0};
                if (shifted >= {1'b0, cell_size_reg})
                begin
                    shifted = shifted - {1'b0, cell_size_reg};
                    q[0]    = 1'b1;
                end
                r = shifted[PW-1:0];
            end
            rem_next[i] = r;
            quo_next[i] = q;
        end
    end

    // voxel coordinates, range check and flat address
    always_comb
    begin : addr_comb
        logic [CW-1:0] cx, cy, cz;
        logic          dep_in, rd_in;
        dep_in = (quo_reg[0] < PW'(GRID_SIDE)) && (quo_reg[1] < PW'(GRID_SIDE))
                 && (quo_reg[2] < PW'(GRID_SIDE));
        rd_in  = (32'(item_reg.read_x) < GRID_SIDE) && (32'(item_reg.read_y) < GRID_SIDE)
                 && (32'(item_reg.read_z) < GRID_SIDE);
        if (item_reg.func)
        begin
            cx          = CW'(item_reg.read_x);
            cy          = CW'(item_reg.read_y);
            cz          = CW'(item_reg.read_z);
            inside_next = rd_in;
        end
        else
        begin
            cx          = CW'(quo_reg[0]);
            cy          = CW'(quo_reg[1]);
            cz          = CW'(quo_reg[2]);
            inside_next = dep_in;
        end
        addr_next = (AW'(cx) * AW'(GRID_SIDE) + AW'(cy)) * AW'(GRID_SIDE) + AW'(cz);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            for (int i = 0; i < 3; i++)
            begin
                quo_reg[i] <= pos_in[i];
                rem_reg[i] <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                quo_reg[i] <= quo_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
        if (cmd.calc_addr)
        begin
            addr_reg   <= addr_next;
            inside_reg <= inside_next;
        end
        if (cmd.mem_upd)
        begin
            result_reg <= result_next;
        end
    end

    // saturating accumulate
    assign sum     = {1'b0, mem_rdata} + vmb_pkg::SUM_W'(item_reg.mass);
    assign sum_sat = sum[TW] ? vmb_pkg::TOTAL_MAX : sum[TW-1:0];

    always_comb
    begin
        result_next = '0;
        if (item_reg.func)
        begin
            result_next.voxel_x = item_reg.read_x;
            result_next.voxel_y = item_reg.read_y;
            result_next.voxel_z = item_reg.read_z;
            result_next.in_grid = 1'b1;
            if (inside_reg)
            begin
                result_next.voxel_mass = mem_rdata;
                result_next.saturated  = (mem_rdata == vmb_pkg::TOTAL_MAX);
            end
        end
        else if (inside_reg)
        begin
            result_next.voxel_x    = vmb_pkg::IDX_W'(quo_reg[0]);
            result_next.voxel_y    = vmb_pkg::IDX_W'(quo_reg[1]);
            result_next.voxel_z    = vmb_pkg::IDX_W'(quo_reg[2]);
            result_next.voxel_mass = sum_sat;
            result_next.in_grid    = 1'b1;
            result_next.saturated  = (sum_sat == vmb_pkg::TOTAL_MAX);
        end
    end

    // memory port: clearing sweep, lookup, write-back
    assign wr_upd    = cmd.mem_upd && inside_reg
                       && (!item_reg.func || item_reg.clear_after_read);
    assign mem_we    = cmd.clr_wr || wr_upd;
    assign mem_en    = mem_we || cmd.mem_rd;
    assign mem_addr  = cmd.clr_wr ? clr_cnt_reg : addr_reg;
    assign mem_wdata = (cmd.clr_wr || item_reg.func) ? '0 : sum_sat;

    vmb_ram #(
        .WIDTH (TW),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign result = result_reg;

endmodule

`default_nettype wire

### src/voxel_mass_binning.sv
`timescale 1ns / 1ps
`default_nettype none

// Nearest-grid-point mass binning into a GRID_SIDE^3 voxel store.
// Command channel: a word on item is taken at a clock edge with start high
// and busy low. func=0 deposits a particle (position / cell_size picks the
// voxel, mass is added with saturation); func=1 reads one voxel, optionally
// clearing it afterwards.
// Result channel: one word per command on result, marked by done for exactly
// one cycle. The receiver cannot stall; the word must be captured then.
// Sequence: a deposit passes through the radix-8 restoring divider (three
// lanes, one per axis, 3 quotient bits per cycle), then address, memory read
// and write-back. A read skips the divider and goes straight to address,
// memory read and update. No new command is taken until the previous one has
// finished. The single memory port sets the read/modify/write sequence.
// Config: cell_size is written through cfg_valid/cfg_ready/cfg_data. The user
// must write it only while no command is in flight; the block does not
// enforce this. It resets to 10.0 (Q14.10).
// Reset: after rst_n rises the grid store is zeroed one entry per cycle,
// all GRID_SIDE^3 entries (32768 at the default), with busy high throughout.
module voxel_mass_binning #(
    parameter int GRID_SIDE = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire vmb_pkg::item_t            item,
    output logic                           done,
    output vmb_pkg::result_t               result,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [vmb_pkg::POS_W-1:0] cfg_data
);

    vmb_pkg::dp_cmd_t    cmd;
    vmb_pkg::dp_status_t status;

    // register write is always taken
    assign cfg_ready = 1'b1;

    vmb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (item.func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    vmb_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .item     (item),
        .cmd      (cmd),
        .status   (status),
        .result   (result)
    );

endmodule

`default_nettype wire

### src/vmb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module vmb_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic                      busy,
    input  wire logic                      done,
    input  wire vmb_pkg::result_t          result
);

    // accepted command keeps the block busy next cycle
    `VMB_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // result word shows only as the block goes idle after work
    `VMB_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy && $past(busy))
    // off-grid deposit reports nothing
    `VMB_ASSERT_SAME(a_off_grid, clk, rst_n, done && !result.in_grid,
        result.voxel_mass == '0 && !result.saturated)
    // saturation flag matches a full-scale total
    `VMB_ASSERT_SAME(a_sat_flag, clk, rst_n, done,
        result.saturated == (result.voxel_mass == vmb_pkg::TOTAL_MAX))

endmodule

bind voxel_mass_binning vmb_checker u_vmb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .result    (result)
);

`default_nettype wire
